// File: design/psbf_pkg.sv
`default_nettype none

package psbf_pkg;

    // Binding table geometry
    localparam int PORTS   = 256;
    localparam int PORT_AW = (PORTS > 1) ? $clog2(PORTS) : 1;

    typedef logic [PORT_AW-1:0] port_idx_t;

    // Header constants
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

    // Presence flag bit positions
    localparam int FL_STATS = 0;
    localparam int FL_MAC   = 1;
    localparam int FL_IP    = 2;

    // Function codes
    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_WRITE    = 1'b1;

    // Verdict reason codes
    localparam logic [3:0] WHY_SHORT    = 4'd0;
    localparam logic [3:0] WHY_NOT_IP   = 4'd1;
    localparam logic [3:0] WHY_IP_SHORT = 4'd2;
    localparam logic [3:0] WHY_MISSING  = 4'd3;
    localparam logic [3:0] WHY_BCAST    = 4'd4;
    localparam logic [3:0] WHY_TOWARD   = 4'd5;
    localparam logic [3:0] WHY_MAC_BAD  = 4'd6;
    localparam logic [3:0] WHY_IP_BAD   = 4'd7;
    localparam logic [3:0] WHY_MATCH    = 4'd8;
    localparam logic [3:0] WHY_WRITTEN  = 4'd9;

    // One row of the binding table
    typedef struct packed {
        logic [2:0]  flags;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] pass_cnt;
        logic [31:0] drop_cnt;
    } entry_t;

    // Input item held in the compute stage
    typedef struct packed {
        logic        func;
        logic [7:0]  port;
        logic        frame_short;
        logic [15:0] ethertype;
        logic        ip_short;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic        has_stats;
        logic        has_mac;
        logic        has_ip;
    } item_t;

    // Verdict of one item
    typedef struct packed {
        logic        drop;
        logic [3:0]  why;
        logic [31:0] pass_total;
        logic [31:0] drop_total;
    } result_t;

    // Write-back request into the table
    typedef struct packed {
        logic   en;
        entry_t data;
    } wback_t;

    function automatic logic port_in_range(input logic [7:0] p);
        return 32'(p) < 32'(PORTS);
    endfunction

    function automatic port_idx_t port_index(input logic [7:0] p);
        return PORT_AW'(p);
    endfunction

endpackage

`default_nettype wire

// File: design/port_source_binding_filter.sv
// Input to result: registered table read, then check and write-back, then the output register.
// Throughput: one item per cycle unless the output stalls; one table read and one write-back per
// item set this figure, and back-to-back items on the same port get the previous write-back by
// forwarding. Reset: asynchronous, active low; clears the presence bit of every entry at once, so
// the block accepts items in the first cycle after reset with no clearing pass.
`default_nettype none

module port_source_binding_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  port,
    input  wire logic        frame_short,
    input  wire logic [15:0] ethertype,
    input  wire logic        ip_short,
    input  wire logic [47:0] dst_mac,
    input  wire logic [47:0] src_mac,
    input  wire logic [31:0] src_ip,
    input  wire logic        has_stats,
    input  wire logic        has_mac,
    input  wire logic        has_ip,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             drop,
    output logic [3:0]       why,
    output logic [31:0]      pass_total,
    output logic [31:0]      drop_total
);
    import psbf_pkg::*;

    logic    accept;
    logic    s2_go;
    logic    s2_valid_reg;
    item_t   s2_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    fwd_hit_reg;
    entry_t  fwd_data_reg;
    entry_t  rd_entry;
    entry_t  s2_entry;
    result_t s2_res;
    wback_t  s2_wb;
    item_t   in_item;

    assign in_item = '{func: func, port: port, frame_short: frame_short,
                       ethertype: ethertype, ip_short: ip_short, dst_mac: dst_mac,
                       src_mac: src_mac, src_ip: src_ip, has_stats: has_stats,
                       has_mac: has_mac, has_ip: has_ip};

    // Handshake: compute stage moves on when the output register is free
    assign s2_go    = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s2_valid_reg && !s2_go;
    assign accept   = in_valid && !in_stall;

    // Binding table
    psbf_entry_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_idx   (port_index(port)),
        .rd_entry (rd_entry),
        .wr_en    (s2_go && s2_wb.en),
        .wr_idx   (port_index(s2_item_reg.port)),
        .wr_entry (s2_wb.data)
    );

    // Entry seen by the compute stage: forwarded write-back wins over the read
    assign s2_entry = fwd_hit_reg ? fwd_data_reg : rd_entry;

    psbf_classify u_classify (
        .item  (s2_item_reg),
        .entry (s2_entry),
        .res   (s2_res),
        .wb    (s2_wb)
    );

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
                fwd_hit_reg  <= s2_go && s2_wb.en && (s2_item_reg.port == port);
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_item_reg  <= in_item;
            fwd_data_reg <= s2_wb.data;
        end
        if (s2_go)
        begin
            out_res_reg <= s2_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drop       = out_res_reg.drop;
    assign why        = out_res_reg.why;
    assign pass_total = out_res_reg.pass_total;
    assign drop_total = out_res_reg.drop_total;

`ifndef SYNTHESIS
    // Forwarding only applies to an item held in the compute stage
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s2_valid_reg)
        else $error("forward hit without an item in the compute stage");

    // Input side is stalled only by a held compute stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // A completed compute stage always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_go |=> out_valid_reg)
        else $error("result lost between compute stage and output");

    // Entry writes never report a drop
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.why == WHY_WRITTEN) |-> !out_res_reg.drop)
        else $error("write transfer reported as drop");
`endif

endmodule

`default_nettype wire

// File: design/psbf_entry_mem.sv
`default_nettype none

module psbf_entry_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire psbf_pkg::port_idx_t rd_idx,
    output psbf_pkg::entry_t       rd_entry,
    input  wire logic              wr_en,
    input  wire psbf_pkg::port_idx_t wr_idx,
    input  wire psbf_pkg::entry_t  wr_entry
);
    import psbf_pkg::*;

    entry_t           mem [PORTS];
    logic [PORTS-1:0] present_reg;
    entry_t           rd_data_reg;
    logic             rd_present_reg;

    // Table storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Per-entry written bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                present_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_present_reg <= present_reg[rd_idx];
            end
        end
    end

    // An entry never written reads with no flags present
    always_comb
    begin
        rd_entry = rd_data_reg;
        if (!rd_present_reg)
        begin
            rd_entry.flags = 3'b000;
        end
    end

endmodule

`default_nettype wire

// File: design/psbf_classify.sv
`default_nettype none

module psbf_classify (
    input  wire psbf_pkg::item_t   item,
    input  wire psbf_pkg::entry_t  entry,
    output psbf_pkg::result_t      res,
    output psbf_pkg::wback_t       wb
);
    import psbf_pkg::*;

    logic        in_range;
    logic [2:0]  flags;
    logic [31:0] p_cur;
    logic [31:0] d_cur;
    logic [31:0] p_inc;
    logic [31:0] d_inc;

    assign in_range = port_in_range(item.port);
    assign flags    = in_range ? entry.flags : 3'b000;
    assign p_cur    = flags[FL_STATS] ? entry.pass_cnt : 32'd0;
    assign d_cur    = flags[FL_STATS] ? entry.drop_cnt : 32'd0;
    assign p_inc    = entry.pass_cnt + 32'd1;
    assign d_inc    = entry.drop_cnt + 32'd1;

    // Ordered check chain; first check that applies decides
    always_comb
    begin
        res.drop       = 1'b0;
        res.why        = WHY_WRITTEN;
        res.pass_total = p_cur;
        res.drop_total = d_cur;
        wb.en          = 1'b0;
        wb.data        = entry;

        if (item.func == FUNC_WRITE)
        begin
            res.pass_total      = 32'd0;
            res.drop_total      = 32'd0;
            wb.en               = in_range;
            wb.data.flags       = {item.has_ip, item.has_mac, item.has_stats};
            wb.data.mac         = item.src_mac;
            wb.data.ip          = item.src_ip;
            wb.data.pass_cnt    = 32'd0;
            wb.data.drop_cnt    = 32'd0;
        end
        else if (item.frame_short)
        begin
            res.drop = 1'b1;
            res.why  = WHY_SHORT;
        end
        else if (item.ethertype != ETH_IPV4)
        begin
            res.why = WHY_NOT_IP;
        end
        else if (item.ip_short)
        begin
            res.why = WHY_IP_SHORT;
        end
        else if (flags != 3'b111)
        begin
            res.why = WHY_MISSING;
        end
        else if (item.src_mac == MAC_BCAST || item.dst_mac == MAC_BCAST)
        begin
            res.why = WHY_BCAST;
        end
        else if (item.dst_mac == entry.mac)
        begin
            res.why = WHY_TOWARD;
        end
        else if (item.src_mac != entry.mac)
        begin
            res.drop         = 1'b1;
            res.why          = WHY_MAC_BAD;
            res.drop_total   = d_inc;
            wb.en            = 1'b1;
            wb.data.drop_cnt = d_inc;
        end
        else if (item.src_ip != entry.ip)
        begin
            res.drop         = 1'b1;
            res.why          = WHY_IP_BAD;
            res.drop_total   = d_inc;
            wb.en            = 1'b1;
            wb.data.drop_cnt = d_inc;
        end
        else
        begin
            res.why          = WHY_MATCH;
            res.pass_total   = p_inc;
            wb.en            = 1'b1;
            wb.data.pass_cnt = p_inc;
        end
    end

endmodule

`default_nettype wire
